// File: src/wvar_pkg.sv
// shared types, constants and lookup functions of the windowed variance unit
// no dependencies; imported by wvar_div, windowed_three_axis_variance_unit and both testbench files
package wvar_pkg;

    localparam int MAX_WINDOW   = 256;
    localparam int ADDR_W       = 8;
    localparam int CNT_W        = 9;
    localparam int FRAC_BITS    = 16;
    localparam int WORK_BITS    = 30;
    localparam int WORK_SH      = WORK_BITS - FRAC_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_W        = 56;

    // angle constants in Q.30, held at the width of the wrap datapath
    localparam logic signed [49:0] PI_W       = 50'sd3373259426;
    localparam logic signed [49:0] TWO_PI_W   = 50'sd6746518852;
    localparam logic signed [49:0] HALF_PI_W  = 50'sd1686629713;
    localparam logic signed [49:0] TWO_PI_TOP = TWO_PI_W <<< WORK_SH;

    localparam logic [47:0] VAR_MAX = {48{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_ANGLE  = 2'd1;

    // request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic [47:0]        var_x;
        logic [47:0]        var_y;
        logic [47:0]        var_z;
        logic               variance_ready;
        logic [8:0]         fill_count;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [8:0]       divisor;
    } t_div_req;

    // window length clamped to the supported range
    function automatic logic [CNT_W-1:0] eff_win(input logic [8:0] w);
        logic [CNT_W-1:0] r;
        r = w;
        if (w < 9'd2) begin
            r = 9'd2;
        end else if (w > 9'(MAX_WINDOW)) begin
            r = 9'(MAX_WINDOW);
        end
        return r;
    endfunction

    // arctangent of 2^-i, truncated Q.30
    function automatic logic [29:0] atan_tab(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/wvar_div.sv
// restoring divider, one quotient bit per cycle, unsigned 56 by 9 bits
// depends on wvar_pkg for the request struct and widths
module wvar_div
    import wvar_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic [DIV_W-1:0] r_quo;
    logic [8:0]       r_rem;
    logic [8:0]       r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [9:0] shifted;
    logic       fits;
    logic [9:0] diff;

    // trial subtraction of the divisor from the shifted remainder
    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? diff[8:0] : shifted[8:0];
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/windowed_three_axis_variance_unit.sv
// top level: sample window memory, mean / variance sequencer and shared cordic
// depends on wvar_pkg and wvar_div
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_in (t_in_item)
//  output    out        o_out_valid / i_out_ready  o_out (t_out_item)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one transaction at a time; the three axes are worked one after another over
// a sample memory with a registered read, each entry fetched and then used.
// linear mode: per axis two memory walks over the n samples held and two 56-bit
// divisions; angle mode: per axis the work is set by the 15-step angle wrap
// and the 16-step cordic run per entry.
// reset is synchronous, active low; the memory needs no clearing pass.
// a finished result waits in the output register while the next transaction is
// taken; the sequencer stalls at its end only if that register is still full.
module windowed_three_axis_variance_unit
    import wvar_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_AXIS, M_FETCH, M_USE, W_RED, W_END, SC_ROT, SC_ACC,
        M_LDIV, M_LWAIT, AT_INIT, AT_NORM, AT_ROT, AT_END, V_START,
        V_FETCH, V_USE, V_SQ, V_ACC, V_DIV, V_WAIT, S_NEXT, S_DONE
    } t_state;

    t_state r_state;

    // configuration and window bookkeeping
    logic [8:0]        r_win_len;
    logic              r_angle;
    logic [ADDR_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_held;

    // sample memory, one row holds x, y, z
    logic [95:0]       r_mem [MAX_WINDOW];
    logic [ADDR_W-1:0] r_addr;
    logic [95:0]       r_rd;

    // sequencer datapath
    logic [1:0]         r_axis;
    logic [CNT_W-1:0]   r_k;
    logic               r_wrap_var;
    logic signed [49:0] r_t;
    logic [3:0]         r_j;
    logic signed [43:0] r_cx;
    logic signed [43:0] r_cy;
    logic signed [34:0] r_cz;
    logic [4:0]         r_step;
    logic               r_neg;
    logic signed [41:0] r_sc;
    logic signed [41:0] r_ss;
    logic signed [31:0] r_mean;
    logic [31:0]        r_abs;
    logic [63:0]        r_sq;
    logic [71:0]        r_acc;
    logic signed [31:0] r_mean_a [3];
    logic [47:0]        r_var_a  [3];

    t_out_item r_out;
    logic      r_out_valid;

    // combinational helpers
    logic [CNT_W-1:0]   win;
    logic               in_acc;
    logic               last_k;
    logic signed [31:0] cur_s;
    logic signed [32:0] dev;
    logic signed [32:0] dev_abs;
    logic signed [49:0] wl_src;
    logic signed [49:0] wl_t;
    logic signed [49:0] red;
    logic signed [49:0] wrapped;
    logic signed [49:0] wr_abs;
    logic signed [49:0] fold_a;
    logic               fold_neg;
    logic signed [43:0] sh_x;
    logic signed [43:0] sh_y;
    logic signed [34:0] atan_v;
    logic signed [43:0] fin_x;
    logic signed [43:0] fin_y;
    logic signed [43:0] sc_w;
    logic signed [43:0] ss_w;
    logic               in_lim;
    logic signed [34:0] mean_rnd;
    logic [41:0]        sum_mag;
    logic [63:0]        sq_w;
    logic [47:0]        var_sat;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    t_div_req           div_req;

    assign win    = eff_win(r_win_len);
    assign in_acc = i_in_valid && o_in_ready;
    assign last_k = (r_k == r_held - 9'd1);

    // axis sample from the registered memory row
    always_comb begin
        unique case (r_axis)
            2'd0:    cur_s = r_rd[95:64];
            2'd1:    cur_s = r_rd[63:32];
            default: cur_s = r_rd[31:0];
        endcase
    end

    // deviation from the current axis mean
    assign dev     = $signed({cur_s[31], cur_s}) - $signed({r_mean[31], r_mean});
    assign dev_abs = (dev < 0) ? -dev : dev;

    // wrap entry: move to Q.30, add pi, lift negative values by a large 2pi multiple
    always_comb begin
        if (r_state == V_USE) begin
            wl_src = {{3{dev[32]}}, dev, 14'b0};
        end else begin
            wl_src = {{4{cur_s[31]}}, cur_s, 14'b0};
        end
        wl_t = wl_src + PI_W;
        if (wl_t < 0) begin
            wl_t = wl_t + TWO_PI_TOP;
        end
    end

    assign red     = TWO_PI_W <<< r_j;
    assign wrapped = r_t - PI_W;
    assign wr_abs  = (wrapped < 0) ? -wrapped : wrapped;

    // fold into [-pi/2, pi/2] ahead of the rotation run
    always_comb begin
        fold_a   = wrapped;
        fold_neg = 1'b0;
        if (wrapped > HALF_PI_W) begin
            fold_a   = wrapped - PI_W;
            fold_neg = 1'b1;
        end else if (wrapped < -HALF_PI_W) begin
            fold_a   = wrapped + PI_W;
            fold_neg = 1'b1;
        end
    end

    // shared cordic terms
    assign sh_x   = r_cx >>> r_step;
    assign sh_y   = r_cy >>> r_step;
    assign atan_v = $signed({5'b0, atan_tab(r_step)});
    assign fin_x  = r_neg ? -r_cx : r_cx;
    assign fin_y  = r_neg ? -r_cy : r_cy;
    assign sc_w   = {{2{r_sc[41]}}, r_sc};
    assign ss_w   = {{2{r_ss[41]}}, r_ss};
    assign in_lim = (r_cx < 44'sh100_0000_0000) && (r_cx > -44'sh100_0000_0000) &&
                    (r_cy < 44'sh100_0000_0000) && (r_cy > -44'sh100_0000_0000);
    assign mean_rnd = (r_cz + 35'sd8192) >>> WORK_SH;

    assign sum_mag = (r_ss < 0) ? 42'(-r_ss) : 42'(r_ss);
    assign sq_w    = r_abs * r_abs;
    assign var_sat = (div_quo > {8'b0, VAR_MAX}) ? VAR_MAX : div_quo[47:0];

    // divider requests: rounded linear mean, then the variance quotient
    always_comb begin
        div_req.start    = (r_state == M_LDIV) || (r_state == V_DIV);
        div_req.dividend = {14'b0, sum_mag} + {48'b0, r_held[8:1]};
        div_req.divisor  = r_held;
        if (r_state == V_DIV) begin
            div_req.divisor = r_held - 9'd1;
            if (r_angle) begin
                div_req.dividend = {28'b0, r_acc[71:44]};
            end else begin
                div_req.dividend = r_acc[71:16];
            end
        end
    end

    wvar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sample memory: write on push, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.req_type == REQ_PUSH)) begin
            r_mem[r_slot] <= {i_in.sample_x, i_in.sample_y, i_in.sample_z};
        end
        r_rd <= r_mem[r_addr];
    end

    // sequencer, bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= 9'd64;
            r_angle     <= 1'b0;
            r_slot      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains; a reload in S_DONE keeps it full
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.req_type == REQ_CLEAR) begin
                            r_held <= '0;
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + 8'd1;
                            r_held <= (r_held < win) ? r_held + 9'd1 : win;
                        end
                        r_axis  <= 2'd0;
                        r_state <= S_AXIS;
                    end
                end
                // start one axis at the newest sample
                S_AXIS: begin
                    r_mean_a[r_axis] <= '0;
                    r_var_a[r_axis]  <= '0;
                    r_k    <= '0;
                    r_addr <= r_slot - 8'd1;
                    r_sc   <= '0;
                    r_ss   <= '0;
                    r_state <= (r_held == '0) ? S_NEXT : M_FETCH;
                end
                M_FETCH: begin
                    r_state <= M_USE;
                end
                M_USE: begin
                    if (r_angle) begin
                        r_t        <= wl_t;
                        r_j        <= 4'(WORK_SH);
                        r_wrap_var <= 1'b0;
                        r_state    <= W_RED;
                    end else begin
                        r_ss <= r_ss + 42'(cur_s);
                        if (last_k) begin
                            r_state <= M_LDIV;
                        end else begin
                            r_k     <= r_k + 9'd1;
                            r_addr  <= r_addr - 8'd1;
                            r_state <= M_FETCH;
                        end
                    end
                end
                // floored reduction by 2pi, one multiple per cycle
                W_RED: begin
                    if (r_t >= red) begin
                        r_t <= r_t - red;
                    end
                    if (r_j == 4'd0) begin
                        r_state <= W_END;
                    end else begin
                        r_j <= r_j - 4'd1;
                    end
                end
                W_END: begin
                    if (r_wrap_var) begin
                        r_abs   <= wr_abs[31:0];
                        r_state <= V_SQ;
                    end else begin
                        r_cz    <= fold_a[34:0];
                        r_neg   <= fold_neg;
                        r_cx    <= 44'sd1073741824;
                        r_cy    <= '0;
                        r_step  <= '0;
                        r_state <= SC_ROT;
                    end
                end
                // sine / cosine rotation steps
                SC_ROT: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - sh_y;
                        r_cy <= r_cy + sh_x;
                        r_cz <= r_cz - atan_v;
                    end else begin
                        r_cx <= r_cx + sh_y;
                        r_cy <= r_cy - sh_x;
                        r_cz <= r_cz + atan_v;
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= SC_ACC;
                    end
                end
                SC_ACC: begin
                    r_sc <= r_sc + fin_x[41:0];
                    r_ss <= r_ss + fin_y[41:0];
                    if (last_k) begin
                        r_state <= AT_INIT;
                    end else begin
                        r_k     <= r_k + 9'd1;
                        r_addr  <= r_addr - 8'd1;
                        r_state <= M_FETCH;
                    end
                end
                M_LDIV: begin
                    r_neg   <= (r_ss < 0);
                    r_state <= M_LWAIT;
                end
                M_LWAIT: begin
                    if (div_done) begin
                        r_mean  <= r_neg ? -div_quo[31:0] : div_quo[31:0];
                        r_state <= V_START;
                    end
                end
                // atan2 of the summed cosines and sines
                AT_INIT: begin
                    r_step <= '0;
                    if ((r_sc == '0) && (r_ss == '0)) begin
                        r_cz    <= '0;
                        r_state <= AT_END;
                    end else if (r_sc < 0) begin
                        r_cz    <= (r_ss >= 0) ? PI_W[34:0] : -PI_W[34:0];
                        r_cx    <= -sc_w;
                        r_cy    <= -ss_w;
                        r_state <= AT_NORM;
                    end else begin
                        r_cz    <= '0;
                        r_cx    <= sc_w;
                        r_cy    <= ss_w;
                        r_state <= AT_NORM;
                    end
                end
                AT_NORM: begin
                    if (in_lim) begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end else begin
                        r_state <= AT_ROT;
                    end
                end
                AT_ROT: begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + sh_y;
                        r_cy <= r_cy - sh_x;
                        r_cz <= r_cz + atan_v;
                    end else begin
                        r_cx <= r_cx - sh_y;
                        r_cy <= r_cy + sh_x;
                        r_cz <= r_cz - atan_v;
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= AT_END;
                    end
                end
                AT_END: begin
                    r_mean  <= mean_rnd[31:0];
                    r_state <= V_START;
                end
                // variance walk only when the window is full
                V_START: begin
                    r_mean_a[r_axis] <= r_mean;
                    r_k    <= '0;
                    r_addr <= r_slot - 8'd1;
                    r_acc  <= '0;
                    r_state <= (r_held == win) ? V_FETCH : S_NEXT;
                end
                V_FETCH: begin
                    r_state <= V_USE;
                end
                V_USE: begin
                    if (r_angle) begin
                        r_t        <= wl_t;
                        r_j        <= 4'(WORK_SH);
                        r_wrap_var <= 1'b1;
                        r_state    <= W_RED;
                    end else begin
                        r_abs   <= dev_abs[31:0];
                        r_state <= V_SQ;
                    end
                end
                V_SQ: begin
                    r_sq    <= sq_w;
                    r_state <= V_ACC;
                end
                V_ACC: begin
                    r_acc <= r_acc + {8'b0, r_sq};
                    if (last_k) begin
                        r_state <= V_DIV;
                    end else begin
                        r_k     <= r_k + 9'd1;
                        r_addr  <= r_addr - 8'd1;
                        r_state <= V_FETCH;
                    end
                end
                V_DIV: begin
                    r_state <= V_WAIT;
                end
                V_WAIT: begin
                    if (div_done) begin
                        r_var_a[r_axis] <= var_sat;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_axis == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_AXIS;
                    end
                end
                // hand the transaction to the output register
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.mean_x         <= r_mean_a[0];
                        r_out.mean_y         <= r_mean_a[1];
                        r_out.mean_z         <= r_mean_a[2];
                        r_out.var_x          <= r_var_a[0];
                        r_out.var_y          <= r_var_a[1];
                        r_out.var_z          <= r_var_a[2];
                        r_out.variance_ready <= (r_held == win);
                        r_out.fill_count     <= r_held;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes; a shrink drops the oldest samples
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW) begin
                    r_win_len <= i_cfg_data;
                    if (r_held > eff_win(i_cfg_data)) begin
                        r_held <= eff_win(i_cfg_data);
                    end
                end else if (i_cfg_idx == CFG_ANGLE) begin
                    r_angle <= i_cfg_data[0];
                end
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: tb/wvar_scoreboard.sv
// scoreboard for the windowed variance unit: follows the config port, predicts
// every result from accepted input transactions and compares the outputs; uses wvar_pkg
`timescale 1ns / 100ps

module wvar_scoreboard
    import wvar_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ATAN_Q30 [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767};
    localparam int EXP_DEPTH = 64;

    // predicted window contents and settings
    logic signed [31:0] win_mem [3][256];
    logic [7:0]         slot_wr;
    int                 held_n;
    logic [8:0]         win_len;
    logic               circ_mode;

    // predicted results in flight, written at exp_wr and read at exp_rd
    t_out_item          exp_buf [EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;

    function automatic int window_size();
        if (win_len < 9'd2) return 2;
        if (win_len > 9'd256) return 256;
        return int'(win_len);
    endfunction

    function automatic longint wrap_q30(input longint a);
        longint r;
        r = (a + PI_Q30) % TWO_PI_Q30;
        if (r < 0) r += TWO_PI_Q30;
        return r - PI_Q30;
    endfunction

    // k-th newest sample of an axis
    function automatic longint newest(input int ax, input int k);
        logic [7:0] s;
        longint v;
        s = slot_wr - 8'd1 - k[7:0];
        v = win_mem[ax][s];
        return v;
    endfunction

    // unscaled cordic rotation, folded into the right half plane
    function automatic void sin_cos_q30(input longint ang, output longint c,
                                        output longint s);
        longint a, x, y, nx, ny;
        bit flip;
        a = wrap_q30(ang);
        x = 64'sd1 <<< 30;
        y = 0;
        flip = 0;
        if (a > HALF_PI_Q30) begin
            a -= PI_Q30;
            flip = 1;
        end else if (a < -HALF_PI_Q30) begin
            a += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                a -= ATAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                a += ATAN_Q30[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint atan2_q30(input longint y_in, input longint x_in);
        longint x, y, z, nx, ny, lim;
        x = x_in;
        y = y_in;
        z = 0;
        lim = 64'sd1 <<< 40;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30 : -PI_Q30;
            x = -x;
            y = -y;
        end
        while (x < lim && x > -lim && y < lim && y > -lim) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_Q30[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_Q30[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint axis_mean(input int ax, input int n);
        longint sum, sc, ss, c, s, mag, q;
        sum = 0;
        sc = 0;
        ss = 0;
        if (circ_mode) begin
            for (int k = 0; k < n; k++) begin
                sin_cos_q30(newest(ax, k) <<< 14, c, s);
                sc += c;
                ss += s;
            end
            return (atan2_q30(ss, sc) + (64'sd1 <<< 13)) >>> 14;
        end
        for (int k = 0; k < n; k++) sum += newest(ax, k);
        mag = (sum < 0) ? -sum : sum;
        q = (mag + n / 2) / n;
        return (sum < 0) ? -q : q;
    endfunction

    function automatic logic [47:0] axis_variance(input int ax, input int n,
                                                  input longint m);
        logic [127:0] acc, t;
        longint d;
        longint unsigned a;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            d = newest(ax, k) - m;
            if (circ_mode) d = wrap_q30(d <<< 14);
            a = (d < 0) ? -d : d;
            acc += 128'(a) * 128'(a);
        end
        t = acc >> (circ_mode ? 44 : 16);
        t = t / 128'(n - 1);
        return (t > 128'(VAR_MAX)) ? VAR_MAX : t[47:0];
    endfunction

    // apply one transaction to the window and build its result
    function automatic t_out_item window_step(input t_in_item it);
        t_out_item r;
        int w;
        longint m [3];
        logic [47:0] v [3];
        w = window_size();
        r = '0;
        if (it.req_type == REQ_CLEAR) begin
            held_n = 0;
            slot_wr = '0;
        end else begin
            win_mem[0][slot_wr] = it.sample_x;
            win_mem[1][slot_wr] = it.sample_y;
            win_mem[2][slot_wr] = it.sample_z;
            slot_wr++;
            if (held_n < w) held_n++;
            else held_n = w;
        end
        for (int ax = 0; ax < 3; ax++) begin
            m[ax] = (held_n > 0) ? axis_mean(ax, held_n) : 0;
            v[ax] = (held_n == w) ? axis_variance(ax, held_n, m[ax]) : '0;
        end
        r.mean_x = m[0][31:0];
        r.mean_y = m[1][31:0];
        r.mean_z = m[2][31:0];
        r.var_x = v[0];
        r.var_y = v[1];
        r.var_z = v[2];
        r.variance_ready = (held_n == w);
        r.fill_count = held_n[8:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            o_errors++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name,
                     exp_v, got_v);
        end
    endtask

    // follow config, predict on input, compare on output
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            slot_wr = '0;
            held_n = 0;
            win_len = 9'd64;
            circ_mode = 1'b0;
            exp_wr = 0;
            exp_rd = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW) begin
                    win_len = i_cfg_data;
                    if (held_n > window_size()) held_n = window_size();
                end else if (i_cfg_idx == CFG_ANGLE) begin
                    circ_mode = i_cfg_data[0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                exp_buf[exp_wr % EXP_DEPTH] = window_step(i_in);
                exp_wr++;
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    o_errors++;
                    $display("%0t unexpected result: expected none actual %h",
                             $time, i_out);
                end else begin
                    e = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    check_field("mean_x", 64'(e.mean_x), 64'(i_out.mean_x));
                    check_field("mean_y", 64'(e.mean_y), 64'(i_out.mean_y));
                    check_field("mean_z", 64'(e.mean_z), 64'(i_out.mean_z));
                    check_field("var_x", 64'(e.var_x), 64'(i_out.var_x));
                    check_field("var_y", 64'(e.var_y), 64'(i_out.var_y));
                    check_field("var_z", 64'(e.var_z), 64'(i_out.var_z));
                    check_field("variance_ready", 64'(e.variance_ready),
                                64'(i_out.variance_ready));
                    check_field("fill_count", 64'(e.fill_count),
                                64'(i_out.fill_count));
                end
            end
        end
        o_pending = exp_wr - exp_rd;
    end

endmodule

// File: tb/windowed_three_axis_variance_unit_tb.sv
// testbench top for the windowed variance unit: clock, reset, stimulus phases
// and verdict; depends on wvar_pkg, wvar_scoreboard and the block itself
`timescale 1ns / 100ps

module windowed_three_axis_variance_unit_tb;
    import wvar_pkg::*;

    localparam int N_PHASES = 7;
    // per phase: window write (-1 keeps reset value), angle mode, count, clear %
    localparam int PH_WIN [N_PHASES]   = '{-1, 1, 0, 511, 3, 12, 7};
    localparam int PH_ANGLE [N_PHASES] = '{0, 1, 0, 0, 1, 0, 1};
    localparam int PH_COUNT [N_PHASES] = '{70, 150, 110, 258, 120, 140, 100};
    localparam int PH_CLEAR [N_PHASES] = '{5, 8, 6, 0, 8, 6, 8};
    localparam logic signed [31:0] PI_Q16 = 32'sd205887;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_txn = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_txn;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [8:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles = 0;
    logic signed [31:0] cluster_base = '0;

    always #6 i_clk = ~i_clk;

    windowed_three_axis_variance_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_txn),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_txn),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    wvar_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_txn),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_txn),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(fail_count), .o_pending(pending)
    );

    // result side: random stalls plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0 && !hold_done) begin
                out_ready <= 1'b0;
                repeat (hold_cycles - 1) @(negedge i_clk);
                hold_done = 1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // hard stop
    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_txn(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_txn <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        t_in_item it;
        it.req_type = REQ_PUSH;
        it.sample_x = x;
        it.sample_y = y;
        it.sample_z = z;
        send_txn(it);
    endtask

    // write a register once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(4))
            0: return $urandom;
            1: case ($urandom_range(5))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0000_0000;
                   3: return 32'hFFFF_FFFF;
                   4: return PI_Q16;
                   default: return -PI_Q16;
               endcase
            2: return $signed($urandom_range(2 ** 21)) - 32'sd1048576;
            default: return cluster_base + $signed($urandom_range(40000)) - 32'sd20000;
        endcase
    endfunction

    function automatic t_in_item random_txn(input int clear_pct);
        t_in_item it;
        it.req_type = ($urandom_range(99) < clear_pct) ? REQ_CLEAR : REQ_PUSH;
        it.sample_x = pick_sample();
        it.sample_y = pick_sample();
        it.sample_z = pick_sample();
        return it;
    endfunction

    initial begin
        t_in_item it;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clear on empty, field extremes, bit patterns, ignored clear data
        it = '0;
        it.req_type = REQ_CLEAR;
        send_txn(it);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001);
        push_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        it.sample_x = 32'hFFFF_FFFF;
        it.sample_y = 32'h1234_5678;
        it.sample_z = 32'h8000_0000;
        send_txn(it);
        push_sample(PI_Q16, -PI_Q16, 32'h0001_0000);
        push_sample(-PI_Q16, PI_Q16, 32'hFFFF_0000);
        for (int i = 0; i < 12; i++) begin
            push_sample(32'h0000_8000 * i, -32'sd3 * i, i);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (PH_WIN[p] >= 0) write_reg(CFG_WINDOW, 9'(PH_WIN[p]));
            if (p > 0) write_reg(CFG_ANGLE, 9'(PH_ANGLE[p]));
            if (p == 5) begin
                // unmapped register indexes must be ignored
                write_reg(2'd2, 9'h1FF);
                write_reg(2'd3, 9'h001);
            end
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
                default: begin send_gap_pct = 37; recv_stall_pct = 37; end
            endcase
            // long output hold-off so the block backs up into its input
            if (p == 2) hold_cycles = 3000;
            cluster_base = (p % 2) ? PI_Q16 - 32'sd8000 : $urandom;
            for (int i = 0; i < PH_COUNT[p]; i++) begin
                send_txn(random_txn(PH_CLEAR[p]));
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
